// ===== hw/rtl/event_priority_queue_top_defines.svh =====
// Assertion macros for the event priority queue.
// Used by event_priority_queue_top; expects clk and arst_n in scope.
`ifndef EVENT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define EVENT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define EPQ_ASSERT_IMPLIES(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("epq assertion failed");
`define EPQ_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("epq assertion failed");
`else
`define EPQ_ASSERT_IMPLIES(name, ante, cons)
`define EPQ_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hw/rtl/epq_pkg.sv =====
// Shared types and constants for the event priority queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package epq_pkg;
	localparam int TIME_W     = 48;
	localparam int FINE_W     = 32;
	localparam int TARGET_W   = 16;
	localparam int PAYLOAD_W  = 32;
	localparam int STATUS_W   = 2;
	localparam int OCC_W      = 7;
	localparam int CAPACITY_DEF = 64;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]    event_time;
		logic [FINE_W-1:0]    fine_order;
		logic [TARGET_W-1:0]  target_id;
		logic [PAYLOAD_W-1:0] payload_handle;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/epq_if.sv =====
// Handshake channels of the event priority queue: input and result words.
// Depends on epq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface epq_in_if import epq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [TIME_W-1:0]    event_time;
	logic [FINE_W-1:0]    fine_order;
	logic [TARGET_W-1:0]  target_id;
	logic [PAYLOAD_W-1:0] payload_handle;

	modport source(output valid, action, event_time, fine_order, target_id, payload_handle,
		input ready);
	modport sink(input valid, action, event_time, fine_order, target_id, payload_handle,
		output ready);
endinterface

interface epq_out_if import epq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic                 popped_valid;
	logic [TIME_W-1:0]    popped_time;
	logic [FINE_W-1:0]    popped_fine;
	logic [TARGET_W-1:0]  popped_target;
	logic [PAYLOAD_W-1:0] popped_payload;
	logic [OCC_W-1:0]     occupancy;

	modport source(output valid, status, popped_valid, popped_time, popped_fine,
		popped_target, popped_payload, occupancy, input ready);
	modport sink(input valid, status, popped_valid, popped_time, popped_fine,
		popped_target, popped_payload, occupancy, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/epq_cell.sv =====
// One slot of the sorted systolic store: holds an event, compares it with
// the incoming key and shifts toward its neighbors. Depends on epq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module epq_cell import epq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      left_ge,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	input  entry_t    new_entry,
	output logic      ge,
	output entry_t    entry
);
	entry_t entry_q;

	// empty slots count as "not below" so the new event lands at the tail
	assign ge = !occupied ||
		({entry_q.event_time, entry_q.fine_order, entry_q.target_id} >=
		 {new_entry.event_time, new_entry.fine_order, new_entry.target_id});

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (left_ge) begin
				entry_q <= left_entry;
			end else if (ge) begin
				entry_q <= new_entry;
			end
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
endmodule
`default_nettype wire

// ===== hw/rtl/event_priority_queue_top.sv =====
// Event priority queue top level: chain of sorted cells, count and result register.
// Depends on epq_pkg, epq_if, epq_cell and event_priority_queue_top_defines.svh.
//
// channel   dir  word
// in_ch     in   action, event_time, fine_order, target_id, payload_handle
// out_ch    out  status, popped_valid, popped_*, occupancy
//
// One word per cycle while in_ch.ready is high: an accepted word reaches every
// cell at the same edge, each cell doing one 96-bit key compare against the
// broadcast event, and the result word enters the output register at that edge.
// in_ch.ready drops only while a result is held and out_ch.ready is low.
// Reset clears the count and the output valid; no clearing pass, slots
// at or beyond the count are never read.
`timescale 1ns / 1ps
`default_nettype none
`include "event_priority_queue_top_defines.svh"
module event_priority_queue_top import epq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	epq_in_if.sink       in_ch,
	epq_out_if.source    out_ch
);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_nxt;
	logic          full;
	logic          empty;
	logic          accept;
	logic          is_pop;
	cell_ctl_t     ctl;
	entry_t        new_entry;

	logic   ge_w  [CAPACITY];
	entry_t ent_w [CAPACITY];

	// result register
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 pvalid_q;
	entry_t               popped_q;
	logic [OCC_W-1:0]     occ_q;
	logic [CW+OCC_W-1:0]  cnt_ext;

	assign full   = (cnt_q == CW'(CAPACITY));
	assign empty  = (cnt_q == '0);
	assign is_pop = (in_ch.action == ACT_POP);

	// the output register parts the two sides
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign new_entry.event_time     = in_ch.event_time;
	assign new_entry.fine_order     = in_ch.fine_order;
	assign new_entry.target_id      = in_ch.target_id;
	assign new_entry.payload_handle = in_ch.payload_handle;

	// full inserts and empty pops leave the store untouched
	assign ctl.insert = accept && !is_pop && !full;
	assign ctl.pop    = accept && is_pop && !empty;

	always_comb begin
		cnt_nxt = cnt_q;
		if (ctl.insert) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (ctl.pop) begin
			cnt_nxt = cnt_q - CW'(1);
		end
	end

	assign cnt_ext = {{OCC_W{1'b0}}, cnt_nxt};

	// Cell chain: slot 0 holds the least event. On insert, cells past the
	// insertion point take their left neighbor and the first "not below"
	// cell takes the new event; on pop, every cell takes its right neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   lge;
		entry_t lent;
		entry_t rent;

		if (i == 0) begin : g_head
			assign lge  = 1'b0;
			assign lent = new_entry;
		end else begin : g_body
			assign lge  = ge_w[i-1];
			assign lent = ent_w[i-1];
		end

		// tail shifts in junk on pop; it lies beyond the count
		if (i == CAPACITY - 1) begin : g_tail
			assign rent = new_entry;
		end else begin : g_link
			assign rent = ent_w[i+1];
		end

		epq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (cnt_q > CW'(i)),
			.left_ge     (lge),
			.left_entry  (lent),
			.right_entry (rent),
			.new_entry   (new_entry),
			.ge          (ge_w[i]),
			.entry       (ent_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= STATUS_OK;
			pvalid_q <= 1'b0;
			popped_q <= '0;
			occ_q    <= cnt_ext[OCC_W-1:0];
			if (is_pop) begin
				if (empty) begin
					status_q <= STATUS_EMPTY;
				end else begin
					pvalid_q <= 1'b1;
					popped_q <= ent_w[0];
				end
			end else if (full) begin
				status_q <= STATUS_FULL;
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = status_q;
	assign out_ch.popped_valid   = pvalid_q;
	assign out_ch.popped_time    = popped_q.event_time;
	assign out_ch.popped_fine    = popped_q.fine_order;
	assign out_ch.popped_target  = popped_q.target_id;
	assign out_ch.popped_payload = popped_q.payload_handle;
	assign out_ch.occupancy      = occ_q;

	`EPQ_ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY))
	`EPQ_ASSERT_NEXT(a_full_drop, accept && !is_pop && full, status_q == STATUS_FULL && cnt_q == $past(cnt_q))
	`EPQ_ASSERT_NEXT(a_pop_dec, ctl.pop, pvalid_q && cnt_q == $past(cnt_q) - CW'(1))
	`EPQ_ASSERT_IMPLIES(a_stall_blocks, out_valid_q && !out_ch.ready, !in_ch.ready)
endmodule
`default_nettype wire
